@@ hw/rtl/pfi_pkg.sv @@
// ----------------------------------------------------------------------------
// pfi_pkg
// Shared types, codes, constants and helpers of the particle force integrator:
// command and register codes, controller states, control bundle, saturation.
// ----------------------------------------------------------------------------
package pfi_pkg;

  // Word formats
  localparam int WORD_W            = 32;
  localparam int DT_W              = 16;
  localparam int STEP_FRAC         = 16;
  localparam int PROD_W            = 64;
  localparam int WIDE_W            = 66;
  localparam int AXES              = 3;
  localparam int AXIS_W            = 2;
  localparam int CMD_W             = 2;
  localparam int CFG_IDX_W         = 3;
  localparam int FRACTION_BITS_DEF = 16;

  localparam logic [WORD_W-1:0] INV_MASS_RST  = 32'd65536;
  localparam logic [DT_W-1:0]   TIME_STEP_RST = 16'd655;

  // Item commands
  typedef enum logic [CMD_W-1:0] {
    CMD_ADD     = 2'd0,
    CMD_STEP    = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_HOLD    = 2'd3
  } pfi_cmd_code_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INV_MASS  = 3'd0,
    CFG_TIME_STEP = 3'd1,
    CFG_START_PX  = 3'd2,
    CFG_START_PY  = 3'd3,
    CFG_START_PZ  = 3'd4,
    CFG_START_VX  = 3'd5,
    CFG_START_VY  = 3'd6,
    CFG_START_VZ  = 3'd7
  } pfi_cfg_idx_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD,
    ST_LOAD,
    ST_MUL_ACC,
    ST_ACC,
    ST_MUL_DV,
    ST_DV,
    ST_MUL_HALF,
    ST_MUL_VT,
    ST_POS,
    ST_DONE
  } pfi_state_t;

  // Multiplier operand pairs
  typedef enum logic [1:0] {
    MSEL_FORCE = 2'd0,   // force * inverse mass
    MSEL_ACC   = 2'd1,   // acceleration * time step
    MSEL_DV    = 2'd2,   // delta velocity * time step
    MSEL_VEL   = 2'd3    // new velocity * time step
  } pfi_msel_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic              latch_in;
    logic              add_force;
    logic              load_start;
    logic              mul_en;
    pfi_msel_t         msel;
    logic              acc_en;
    logic              dv_en;
    logic              half_en;
    logic              pos_en;
    logic              out_load;
    logic [AXIS_W-1:0] axis;
  } pfi_ctrl_t;

  // Clamp a wide signed value to the signed word range
  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [WIDE_W-1:0] x);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = {{(WIDE_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
    lo = ~hi;
    if (x > hi) begin
      sat_word = hi[WORD_W-1:0];
    end else if (x < lo) begin
      sat_word = lo[WORD_W-1:0];
    end else begin
      sat_word = x[WORD_W-1:0];
    end
  endfunction

endpackage

@@ hw/rtl/pfi_ctrl.sv @@
// ----------------------------------------------------------------------------
// pfi_ctrl
// Controller: accepts items, sequences the shared multiplier over the three
// axes for an integration step and hands results to the output register.
// ----------------------------------------------------------------------------
module pfi_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [pfi_pkg::CMD_W-1:0]  in_command,
  output logic                       out_valid,
  input  logic                       out_ready,
  output pfi_pkg::pfi_ctrl_t         ctrl
);

  pfi_pkg::pfi_state_t             state_r, state_nxt;
  logic [pfi_pkg::AXIS_W-1:0]      axis_r, axis_nxt;
  logic                            out_valid_r, out_valid_nxt;
  pfi_pkg::pfi_cmd_code_t          cmd_code;

  assign cmd_code  = pfi_pkg::pfi_cmd_code_t'(in_command);
  assign out_valid = out_valid_r;

  // State, axis and output-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pfi_pkg::ST_IDLE;
      axis_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_nxt       = state_r;
    axis_nxt        = axis_r;
    in_ready        = 1'b0;
    ctrl            = '0;
    ctrl.msel       = pfi_pkg::MSEL_FORCE;
    ctrl.axis       = axis_r;

    unique case (state_r)
      pfi_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.latch_in = 1'b1;
          unique case (cmd_code)
            pfi_pkg::CMD_ADD:     state_nxt = pfi_pkg::ST_ADD;
            pfi_pkg::CMD_STEP: begin
              state_nxt = pfi_pkg::ST_MUL_ACC;
              axis_nxt  = '0;
            end
            pfi_pkg::CMD_RESTART: state_nxt = pfi_pkg::ST_LOAD;
            pfi_pkg::CMD_HOLD:    state_nxt = pfi_pkg::ST_DONE;
            default:              state_nxt = pfi_pkg::ST_DONE;
          endcase
        end
      end
      pfi_pkg::ST_ADD: begin
        ctrl.add_force = 1'b1;
        state_nxt      = pfi_pkg::ST_DONE;
      end
      pfi_pkg::ST_LOAD: begin
        ctrl.load_start = 1'b1;
        state_nxt       = pfi_pkg::ST_DONE;
      end
      pfi_pkg::ST_MUL_ACC: begin
        ctrl.mul_en = 1'b1;
        ctrl.msel   = pfi_pkg::MSEL_FORCE;
        state_nxt   = pfi_pkg::ST_ACC;
      end
      pfi_pkg::ST_ACC: begin
        ctrl.acc_en = 1'b1;
        state_nxt   = pfi_pkg::ST_MUL_DV;
      end
      pfi_pkg::ST_MUL_DV: begin
        ctrl.mul_en = 1'b1;
        ctrl.msel   = pfi_pkg::MSEL_ACC;
        state_nxt   = pfi_pkg::ST_DV;
      end
      pfi_pkg::ST_DV: begin
        ctrl.dv_en = 1'b1;
        state_nxt  = pfi_pkg::ST_MUL_HALF;
      end
      pfi_pkg::ST_MUL_HALF: begin
        ctrl.mul_en = 1'b1;
        ctrl.msel   = pfi_pkg::MSEL_DV;
        state_nxt   = pfi_pkg::ST_MUL_VT;
      end
      pfi_pkg::ST_MUL_VT: begin
        ctrl.mul_en  = 1'b1;
        ctrl.msel    = pfi_pkg::MSEL_VEL;
        ctrl.half_en = 1'b1;
        state_nxt    = pfi_pkg::ST_POS;
      end
      pfi_pkg::ST_POS: begin
        ctrl.pos_en = 1'b1;
        if (axis_r == pfi_pkg::AXIS_W'(pfi_pkg::AXES - 1)) begin
          state_nxt = pfi_pkg::ST_DONE;
        end else begin
          axis_nxt  = axis_r + 1'b1;
          state_nxt = pfi_pkg::ST_MUL_ACC;
        end
      end
      pfi_pkg::ST_DONE: begin
        // Wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          ctrl.out_load = 1'b1;
          state_nxt     = pfi_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pfi_pkg::ST_IDLE;
    endcase
  end

  // Output valid: set on load, drop when taken
  always_comb begin
    if (ctrl.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Checks
  a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
    axis_r != 2'd3)
    else $error("axis counter out of range");

  a_step_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && cmd_code == pfi_pkg::CMD_STEP)
      |=> (state_r == pfi_pkg::ST_MUL_ACC && axis_r == '0))
    else $error("step did not start at first axis");

  a_last_axis: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pfi_pkg::ST_POS && axis_r == 2'd2) |=> state_r == pfi_pkg::ST_DONE)
    else $error("step did not finish after last axis");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.out_load |-> (!out_valid_r || out_ready))
    else $error("output register overwritten while full");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.out_load |=> out_valid_r)
    else $error("loaded result not presented");

endmodule

@@ hw/rtl/pfi_datapath.sv @@
// ----------------------------------------------------------------------------
// pfi_datapath
// Datapath: configuration registers, force/velocity/position state, one
// shared registered multiplier with rounding and saturation, output register.
// ----------------------------------------------------------------------------
module pfi_datapath #(
  parameter int FRACTION_BITS = pfi_pkg::FRACTION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [pfi_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pfi_pkg::WORD_W-1:0]          cfg_wdata,
  input  logic signed [pfi_pkg::WORD_W-1:0]   in_force_x,
  input  logic signed [pfi_pkg::WORD_W-1:0]   in_force_y,
  input  logic signed [pfi_pkg::WORD_W-1:0]   in_force_z,
  input  pfi_pkg::pfi_ctrl_t                  ctrl,
  output logic signed [pfi_pkg::WORD_W-1:0]   out_pos_x,
  output logic signed [pfi_pkg::WORD_W-1:0]   out_pos_y,
  output logic signed [pfi_pkg::WORD_W-1:0]   out_pos_z,
  output logic signed [pfi_pkg::WORD_W-1:0]   out_vel_x,
  output logic signed [pfi_pkg::WORD_W-1:0]   out_vel_y,
  output logic signed [pfi_pkg::WORD_W-1:0]   out_vel_z
);

  localparam int W  = pfi_pkg::WORD_W;
  localparam int PW = pfi_pkg::PROD_W;
  localparam int XW = pfi_pkg::WIDE_W;
  localparam logic signed [PW:0] HALF_FB   = (PW+1)'(1) <<< (FRACTION_BITS - 1);
  localparam logic signed [PW:0] HALF_STEP = (PW+1)'(1) <<< (pfi_pkg::STEP_FRAC - 1);
  localparam logic signed [PW:0] HALF_HALF = (PW+1)'(1) <<< pfi_pkg::STEP_FRAC;

  // Configuration
  logic [W-1:0]              inv_mass_r;
  logic [pfi_pkg::DT_W-1:0]  time_step_r;
  logic signed [W-1:0]       start_pos_r [pfi_pkg::AXES];
  logic signed [W-1:0]       start_vel_r [pfi_pkg::AXES];

  // Particle state
  logic signed [W-1:0]       force_r [pfi_pkg::AXES];
  logic signed [W-1:0]       vel_r   [pfi_pkg::AXES];
  logic signed [W-1:0]       pos_r   [pfi_pkg::AXES];

  // Working registers
  logic signed [W-1:0]       in_force_r [pfi_pkg::AXES];
  logic signed [W-1:0]       acc_r;
  logic signed [W-1:0]       dv_r;
  logic signed [W-1:0]       half_r;
  logic signed [PW-1:0]      prod_r;
  logic signed [W-1:0]       out_pos_r [pfi_pkg::AXES];
  logic signed [W-1:0]       out_vel_r [pfi_pkg::AXES];

  // Multiplier and rounding
  logic signed [W-1:0]       mul_a;
  logic signed [W:0]         mul_b;
  logic signed [PW-1:0]      prod_nxt;
  logic signed [PW:0]        prod_ext;
  logic signed [PW:0]        rnd_fb;
  logic signed [PW:0]        rnd_step;
  logic signed [PW:0]        rnd_half;
  logic signed [W-1:0]       acc_nxt;
  logic signed [W-1:0]       vel_nxt;
  logic signed [W-1:0]       pos_nxt;
  logic signed [W-1:0]       force_nxt [pfi_pkg::AXES];
  logic signed [W-1:0]       cur_force;
  logic signed [W-1:0]       cur_vel;
  logic signed [W-1:0]       cur_pos;

  assign cur_force = force_r[ctrl.axis];
  assign cur_vel   = vel_r[ctrl.axis];
  assign cur_pos   = pos_r[ctrl.axis];

  // Select multiplier operands
  always_comb begin
    mul_b = $signed({1'b0, {(W-pfi_pkg::DT_W){1'b0}}, time_step_r});
    unique case (ctrl.msel)
      pfi_pkg::MSEL_FORCE: begin
        mul_a = cur_force;
        mul_b = $signed({1'b0, inv_mass_r});
      end
      pfi_pkg::MSEL_ACC: mul_a = acc_r;
      pfi_pkg::MSEL_DV:  mul_a = dv_r;
      pfi_pkg::MSEL_VEL: mul_a = cur_vel;
      default:           mul_a = acc_r;
    endcase
  end

  assign prod_nxt = PW'(mul_a) * PW'(mul_b);

  // Round half up, then floor by arithmetic shift
  assign prod_ext = {prod_r[PW-1], prod_r};
  assign rnd_fb   = (prod_ext + HALF_FB) >>> FRACTION_BITS;
  assign rnd_step = (prod_ext + HALF_STEP) >>> pfi_pkg::STEP_FRAC;
  assign rnd_half = (prod_ext + HALF_HALF) >>> (pfi_pkg::STEP_FRAC + 1);

  assign acc_nxt = pfi_pkg::sat_word(XW'(rnd_fb));
  assign vel_nxt = pfi_pkg::sat_word(XW'(cur_vel) + XW'($signed(rnd_step[W-1:0])));
  assign pos_nxt = pfi_pkg::sat_word(XW'(cur_pos) + XW'($signed(rnd_step[W-1:0]))
                                     - XW'(half_r));

  // Saturating force accumulation, all axes at once
  always_comb begin
    for (int i = 0; i < pfi_pkg::AXES; i++) begin
      force_nxt[i] = pfi_pkg::sat_word(XW'(force_r[i]) + XW'(in_force_r[i]));
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_mass_r  <= pfi_pkg::INV_MASS_RST;
      time_step_r <= pfi_pkg::TIME_STEP_RST;
      for (int i = 0; i < pfi_pkg::AXES; i++) begin
        start_pos_r[i] <= '0;
        start_vel_r[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (pfi_pkg::pfi_cfg_idx_t'(cfg_index))
        pfi_pkg::CFG_INV_MASS:  inv_mass_r     <= cfg_wdata;
        pfi_pkg::CFG_TIME_STEP: time_step_r    <= cfg_wdata[pfi_pkg::DT_W-1:0];
        pfi_pkg::CFG_START_PX:  start_pos_r[0] <= $signed(cfg_wdata);
        pfi_pkg::CFG_START_PY:  start_pos_r[1] <= $signed(cfg_wdata);
        pfi_pkg::CFG_START_PZ:  start_pos_r[2] <= $signed(cfg_wdata);
        pfi_pkg::CFG_START_VX:  start_vel_r[0] <= $signed(cfg_wdata);
        pfi_pkg::CFG_START_VY:  start_vel_r[1] <= $signed(cfg_wdata);
        pfi_pkg::CFG_START_VZ:  start_vel_r[2] <= $signed(cfg_wdata);
        default:                inv_mass_r     <= inv_mass_r;
      endcase
    end
  end

  // Particle state: add, restart, per-axis integrate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < pfi_pkg::AXES; i++) begin
        force_r[i] <= '0;
        vel_r[i]   <= '0;
        pos_r[i]   <= '0;
      end
    end else begin
      if (ctrl.add_force) begin
        for (int i = 0; i < pfi_pkg::AXES; i++) begin
          force_r[i] <= force_nxt[i];
        end
      end
      if (ctrl.load_start) begin
        for (int i = 0; i < pfi_pkg::AXES; i++) begin
          force_r[i] <= '0;
          vel_r[i]   <= start_vel_r[i];
          pos_r[i]   <= start_pos_r[i];
        end
      end
      if (ctrl.dv_en) begin
        vel_r[ctrl.axis] <= vel_nxt;
      end
      if (ctrl.pos_en) begin
        pos_r[ctrl.axis]   <= pos_nxt;
        force_r[ctrl.axis] <= '0;
      end
    end
  end

  // Input capture, multiplier pipeline and intermediate terms
  always_ff @(posedge clk) begin
    if (ctrl.latch_in) begin
      in_force_r[0] <= in_force_x;
      in_force_r[1] <= in_force_y;
      in_force_r[2] <= in_force_z;
    end
    if (ctrl.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (ctrl.acc_en) begin
      acc_r <= acc_nxt;
    end
    if (ctrl.dv_en) begin
      dv_r <= rnd_step[W-1:0];
    end
    if (ctrl.half_en) begin
      half_r <= rnd_half[W-1:0];
    end
  end

  // Output register: snapshot position and velocity
  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      for (int i = 0; i < pfi_pkg::AXES; i++) begin
        out_pos_r[i] <= pos_r[i];
        out_vel_r[i] <= vel_r[i];
      end
    end
  end

  assign out_pos_x = out_pos_r[0];
  assign out_pos_y = out_pos_r[1];
  assign out_pos_z = out_pos_r[2];
  assign out_vel_x = out_vel_r[0];
  assign out_vel_y = out_vel_r[1];
  assign out_vel_z = out_vel_r[2];

endmodule

@@ hw/rtl/particle_force_integrator_unit.sv @@
// ----------------------------------------------------------------------------
// particle_force_integrator_unit
// Point-mass integrator in three axes, signed fixed point: accumulates force,
// takes trapezoidal-rule steps, restarts from programmed start values.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake          Payload
//  in_       input      in_valid/in_ready  in_command, in_force_x/y/z
//  out_      output     out_valid/out_ready out_pos_x/y/z, out_vel_x/y/z
//  cfg_      input      cfg_we             cfg_index, cfg_wdata
//
//  Add-force and restart pass through ST_ADD or ST_LOAD before the result
//  load, the unused command goes straight to it; a step works each axis in
//  turn on the single shared multiplier (four products per axis, each
//  registered and then rounded) between acceptance and result load.
//  One item is in work at a time; a finished result sits in the output
//  register while the next transaction is accepted and processed.
//  A stalled output holds the controller in ST_DONE, the next result in the
//  particle state, until the output register is taken. Synchronous reset
//  clears the particle state and restores configuration register defaults.
// ----------------------------------------------------------------------------
module particle_force_integrator_unit #(
  parameter int FRACTION_BITS = pfi_pkg::FRACTION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [pfi_pkg::CMD_W-1:0]           in_command,
  input  logic signed [pfi_pkg::WORD_W-1:0]   in_force_x,
  input  logic signed [pfi_pkg::WORD_W-1:0]   in_force_y,
  input  logic signed [pfi_pkg::WORD_W-1:0]   in_force_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [pfi_pkg::WORD_W-1:0]   out_pos_x,
  output logic signed [pfi_pkg::WORD_W-1:0]   out_pos_y,
  output logic signed [pfi_pkg::WORD_W-1:0]   out_pos_z,
  output logic signed [pfi_pkg::WORD_W-1:0]   out_vel_x,
  output logic signed [pfi_pkg::WORD_W-1:0]   out_vel_y,
  output logic signed [pfi_pkg::WORD_W-1:0]   out_vel_z,
  input  logic                                cfg_we,
  input  logic [pfi_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pfi_pkg::WORD_W-1:0]          cfg_wdata
);

  pfi_pkg::pfi_ctrl_t ctrl;

  // Sequencer
  pfi_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .ctrl       (ctrl)
  );

  // Arithmetic and state
  pfi_datapath #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_force_x (in_force_x),
    .in_force_y (in_force_y),
    .in_force_z (in_force_z),
    .ctrl       (ctrl),
    .out_pos_x  (out_pos_x),
    .out_pos_y  (out_pos_y),
    .out_pos_z  (out_pos_z),
    .out_vel_x  (out_vel_x),
    .out_vel_y  (out_vel_y),
    .out_vel_z  (out_vel_z)
  );

endmodule
